/* rtl/suks_pkg.sv */
// ----------------------------------------------------------------------------
// suks_pkg
// Shared types and constants for the sorted unique key set core.
// ----------------------------------------------------------------------------
package suks_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_KEY  = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic signed [KEY_W-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic                    kind;
        logic signed [KEY_W-1:0] out_key;
        logic                    already_present;
        logic                    dropped_full;
        logic [ENTRY_W-1:0]      entry_count;
        logic                    empty_drain;
        logic                    last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_SHIFT,
        ST_RESP,
        ST_DRAIN_RD,
        ST_DRAIN_OUT
    } state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] count;
    } status_t;

endpackage

/* rtl/suks_ram.sv */
// ----------------------------------------------------------------------------
// suks_ram
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module suks_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/suks_ctrl.sv */
// ----------------------------------------------------------------------------
// suks_ctrl
// Sequencer: binary search, shift-up insert and ordered drain over the RAM.
// ----------------------------------------------------------------------------
module suks_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  suks_pkg::in_item_t             s_data,
    input  logic                           res_free,
    output logic                           res_push,
    output suks_pkg::out_item_t            res,
    output suks_pkg::ram_req_t             ram_req,
    input  logic signed [suks_pkg::KEY_W-1:0] ram_rdata,
    output suks_pkg::status_t              status
);

    suks_pkg::state_t state_reg, state_next;

    logic [suks_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [suks_pkg::CNT_W-1:0]        lo_reg, lo_next;
    logic [suks_pkg::CNT_W-1:0]        hi_reg, hi_next;
    logic [suks_pkg::CNT_W-1:0]        mid_reg, mid_next;
    logic [suks_pkg::CNT_W-1:0]        ptr_reg, ptr_next;
    logic [suks_pkg::IDX_W-1:0]        waddr_reg, waddr_next;
    logic                              pend_reg, pend_next;
    logic signed [suks_pkg::KEY_W-1:0] key_reg, key_next;
    suks_pkg::out_item_t               res_reg, res_next;

    logic                              accept;
    logic [suks_pkg::CNT_W:0]          mid_sum;
    logic [suks_pkg::CNT_W-1:0]        mid;
    logic [suks_pkg::CNT_W-1:0]        ptr_dec;
    logic [suks_pkg::CNT_W-1:0]        ptr_inc;
    logic                              key_hit;
    logic                              key_lt;
    logic                              full;
    logic                              drain_last;

    assign accept     = s_valid && s_ready;
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[suks_pkg::CNT_W:1];
    assign ptr_dec    = ptr_reg - 1'b1;
    assign ptr_inc    = ptr_reg + 1'b1;
    assign key_hit    = (ram_rdata == key_reg);
    assign key_lt     = (key_reg < ram_rdata);
    assign full       = (count_reg >= suks_pkg::CNT_W'(suks_pkg::CAPACITY));
    assign drain_last = (ptr_inc == count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            suks_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_data.operation == suks_pkg::OP_INSERT) begin
                        state_next = suks_pkg::ST_SEARCH_RD;
                    end else if (count_reg == '0) begin
                        state_next = suks_pkg::ST_RESP;
                    end else begin
                        state_next = suks_pkg::ST_DRAIN_RD;
                    end
                end
            end
            suks_pkg::ST_SEARCH_RD: begin
                if (lo_reg < hi_reg) begin
                    state_next = suks_pkg::ST_SEARCH_CMP;
                end else if (full) begin
                    state_next = suks_pkg::ST_RESP;
                end else begin
                    state_next = suks_pkg::ST_SHIFT;
                end
            end
            suks_pkg::ST_SEARCH_CMP: begin
                state_next = key_hit ? suks_pkg::ST_RESP : suks_pkg::ST_SEARCH_RD;
            end
            suks_pkg::ST_SHIFT: begin
                if (!pend_reg && ptr_reg == lo_reg) begin
                    state_next = suks_pkg::ST_RESP;
                end
            end
            suks_pkg::ST_RESP: begin
                if (res_free) begin
                    state_next = suks_pkg::ST_IDLE;
                end
            end
            suks_pkg::ST_DRAIN_RD: begin
                state_next = suks_pkg::ST_DRAIN_OUT;
            end
            suks_pkg::ST_DRAIN_OUT: begin
                if (res_free) begin
                    state_next = drain_last ? suks_pkg::ST_IDLE : suks_pkg::ST_DRAIN_RD;
                end
            end
            default: begin
                state_next = suks_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        ptr_next    = ptr_reg;
        waddr_next  = waddr_reg;
        pend_next   = pend_reg;
        key_next    = key_reg;
        res_next    = res_reg;
        s_ready     = 1'b0;
        res_push    = 1'b0;
        res         = res_reg;
        ram_req     = '0;

        case (state_reg)
            suks_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    key_next = s_data.key;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    ptr_next = '0;
                    res_next = '0;
                    if (s_data.operation == suks_pkg::OP_DRAIN) begin
                        res_next.kind        = suks_pkg::KIND_KEY;
                        res_next.empty_drain = 1'b1;
                        res_next.last        = 1'b1;
                    end
                end
            end
            suks_pkg::ST_SEARCH_RD: begin
                res_next             = '0;
                res_next.kind        = suks_pkg::KIND_ACK;
                res_next.last        = 1'b1;
                res_next.entry_count = suks_pkg::ENTRY_W'(count_reg);
                if (lo_reg < hi_reg) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = mid[suks_pkg::IDX_W-1:0];
                    mid_next      = mid;
                end else if (full) begin
                    res_next.dropped_full = 1'b1;
                end else begin
                    ptr_next  = count_reg;
                    pend_next = 1'b0;
                end
            end
            suks_pkg::ST_SEARCH_CMP: begin
                if (key_hit) begin
                    res_next.already_present = 1'b1;
                end else if (key_lt) begin
                    hi_next = mid_reg;
                end else begin
                    lo_next = mid_reg + 1'b1;
                end
            end
            suks_pkg::ST_SHIFT: begin
                // read entry ptr-1, write it one place up next cycle
                if (ptr_reg != lo_reg) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ptr_dec[suks_pkg::IDX_W-1:0];
                    waddr_next    = ptr_reg[suks_pkg::IDX_W-1:0];
                    ptr_next      = ptr_dec;
                    pend_next     = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = waddr_reg;
                    ram_req.wdata = ram_rdata;
                end else if (ptr_reg == lo_reg) begin
                    ram_req.we           = 1'b1;
                    ram_req.waddr        = lo_reg[suks_pkg::IDX_W-1:0];
                    ram_req.wdata        = key_reg;
                    count_next           = count_reg + 1'b1;
                    res_next.entry_count = suks_pkg::ENTRY_W'(count_reg + 1'b1);
                end
            end
            suks_pkg::ST_RESP: begin
                if (res_free) begin
                    res_push = 1'b1;
                end
            end
            suks_pkg::ST_DRAIN_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = ptr_reg[suks_pkg::IDX_W-1:0];
            end
            suks_pkg::ST_DRAIN_OUT: begin
                res         = '0;
                res.kind    = suks_pkg::KIND_KEY;
                res.out_key = ram_rdata;
                res.last    = drain_last;
                if (res_free) begin
                    res_push = 1'b1;
                    ptr_next = ptr_inc;
                    if (drain_last) begin
                        count_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= suks_pkg::ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        ptr_reg   <= ptr_next;
        waddr_reg <= waddr_next;
        key_reg   <= key_next;
        res_reg   <= res_next;
    end

    assign status.idle  = (state_reg == suks_pkg::ST_IDLE);
    assign status.count = count_reg;

endmodule

/* rtl/sorted_unique_key_set_core.sv */
// ----------------------------------------------------------------------------
// sorted_unique_key_set_core
// Ascending table of distinct signed 64-bit keys held in one RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_valid / s_ready  | s_data  (operation, key)
//  m_      | out       | m_valid / m_ready  | m_data  (kind, out_key, flags,
//          |           |                    |          entry_count, last)
//
// Steps: idle accepts the request. Insert then runs search steps (a RAM read,
//   then a compare; up to log2(n)+1 steps) and closes the search; a new key
//   then moves each larger entry up one place and writes the key in; then
//   the acknowledgement is handed over. Drain reads, then presents each
//   stored key in turn; an empty drain answers with one empty-drain result.
// One transaction in flight at a time; s_ready is high only when idle.
// The m_ output register lets a new transaction be accepted while the last
//   result is still waiting on m_ready; m_ stalls hold the sequencer.
// Reset (aresetn, synchronous) clears the count, the sequencer state and the
//   output valid; no clearing pass, RAM contents are don't-care until written.
// ----------------------------------------------------------------------------
module sorted_unique_key_set_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  suks_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output suks_pkg::out_item_t  m_data
);

    suks_pkg::ram_req_t              ram_req;
    logic [suks_pkg::KEY_W-1:0]      ram_rdata;
    suks_pkg::status_t               status;
    suks_pkg::out_item_t             res;
    logic                            res_push;
    logic                            res_free;

    logic                            m_valid_reg;
    suks_pkg::out_item_t             m_data_reg;

    // key store
    suks_ram #(
        .DEPTH (suks_pkg::CAPACITY),
        .WIDTH (suks_pkg::KEY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // search / shift / drain sequencer
    suks_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_free  (res_free),
        .res_push  (res_push),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata ($signed(ram_rdata)),
        .status    (status)
    );

    // output register: free when empty or being taken this cycle
    assign res_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.count <= suks_pkg::CNT_W'(suks_pkg::CAPACITY))
        else $error("key count beyond capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again while a transaction is in progress");

    a_ack_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == suks_pkg::KIND_ACK) |->
            (m_data.last && m_data.out_key == '0 && !m_data.empty_drain))
        else $error("malformed insert acknowledgement");

    a_push_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> res_free)
        else $error("result pushed into a full output register");

endmodule
